// ===== rtl/xml_entity_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the entity decoder
// Clocked, reset-qualified wrappers for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_DECODER_ASSERT_SVH
`define XML_ENTITY_DECODER_ASSERT_SVH

// Check that a property holds on every clock edge outside reset.
`define XED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define XED_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/xed_pkg.sv =====
// ----------------------------------------------------------------------------
// xed_pkg
// Types and constants shared by the entity decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xed_pkg;

  localparam int XED_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } xed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_done;
    logic       entity_error;
  } xed_out_t;

  // At most one job per input transaction: up to four decoded bytes and an
  // optional trailing error or closing result.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            tail_valid;
    logic            tail_done;
    logic            tail_err;
  } xed_job_t;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_NAME,
    MODE_HASH,
    MODE_DIGITS
  } xed_mode_t;

endpackage

`default_nettype wire

// ===== rtl/xed_front.sv =====
// ----------------------------------------------------------------------------
// xed_front
// Entity parser: classifies each byte and builds the job it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xed_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  xed_pkg::xed_in_t in_data,
  output xed_pkg::xed_job_t job,
  output logic             job_push
);
  import xed_pkg::*;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;

  localparam logic [24:0] CP_MAX = 25'h010FFFF;
  localparam logic [20:0] CP_SAT = 21'h1FFFFF;

  xed_mode_t       mode_r, mode_nxt;
  logic            hex_r, hex_nxt;
  logic [3:0][7:0] chars_r, chars_nxt;
  logic [2:0]      len_r, len_nxt;
  logic            bad_r, bad_nxt;
  logic [20:0]     code_r, code_nxt;
  logic            digits_r, digits_nxt;
  logic            discard_r, discard_nxt;

  logic [7:0]  b;
  logic        failed;
  logic        name_ok;
  logic [7:0]  name_out;
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [24:0] dig_sum;
  logic        code_ok;
  logic [3:0][7:0] utf_bytes;
  logic [2:0]  utf_count;

  assign b = in_data.text_byte;

  // Named entity lookup on the stored name.
  always_comb begin
    name_ok  = !bad_r;
    name_out = 8'h00;
    case ({len_r, chars_r})
      {3'd2, 32'h0000746C}: name_out = 8'h3C;
      {3'd2, 32'h00007467}: name_out = 8'h3E;
      {3'd3, 32'h00706D61}: name_out = 8'h26;
      {3'd4, 32'h746F7571}: name_out = 8'h22;
      {3'd4, 32'h736F7061}: name_out = 8'h27;
      {3'd4, 32'h7073626E}: name_out = 8'h20;
      {3'd2, 32'h00007263}: name_out = 8'h0A;
      default: name_ok = 1'b0;
    endcase
  end

  // Digit value and saturating accumulate.
  always_comb begin
    dig_ok  = 1'b1;
    dig_val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      dig_val = b[3:0];
    end else if (hex_r && (b inside {[8'h61:8'h66], [8'h41:8'h46]})) begin
      dig_val = b[3:0] + 4'd9;
    end else begin
      dig_ok = 1'b0;
    end
    if (hex_r) begin
      dig_sum = {code_r, 4'b0000} + {21'd0, dig_val};
    end else begin
      dig_sum = {1'b0, code_r, 3'b000} + {3'b000, code_r, 1'b0} + {21'd0, dig_val};
    end
  end

  // UTF-8 encode of the stored code point.
  always_comb begin
    code_ok = !bad_r && digits_r && (code_r != 21'd0) && (code_r <= CP_MAX[20:0])
              && !(code_r inside {[21'h00D800:21'h00DFFF]});
    utf_bytes = '0;
    if (code_r <= 21'h00007F) begin
      utf_count    = 3'd1;
      utf_bytes[0] = code_r[7:0];
    end else if (code_r <= 21'h0007FF) begin
      utf_count    = 3'd2;
      utf_bytes[0] = {3'b110, code_r[10:6]};
      utf_bytes[1] = {2'b10, code_r[5:0]};
    end else if (code_r <= 21'h00FFFF) begin
      utf_count    = 3'd3;
      utf_bytes[0] = {4'b1110, code_r[15:12]};
      utf_bytes[1] = {2'b10, code_r[11:6]};
      utf_bytes[2] = {2'b10, code_r[5:0]};
    end else begin
      utf_count    = 3'd4;
      utf_bytes[0] = {5'b11110, code_r[20:18]};
      utf_bytes[1] = {2'b10, code_r[17:12]};
      utf_bytes[2] = {2'b10, code_r[11:6]};
      utf_bytes[3] = {2'b10, code_r[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_TEXT;
      hex_r     <= 1'b0;
      chars_r   <= '0;
      len_r     <= 3'd0;
      bad_r     <= 1'b0;
      code_r    <= 21'd0;
      digits_r  <= 1'b0;
      discard_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      hex_r     <= hex_nxt;
      chars_r   <= chars_nxt;
      len_r     <= len_nxt;
      bad_r     <= bad_nxt;
      code_r    <= code_nxt;
      digits_r  <= digits_nxt;
      discard_r <= discard_nxt;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    hex_nxt     = hex_r;
    chars_nxt   = chars_r;
    len_nxt     = len_r;
    bad_nxt     = bad_r;
    code_nxt    = code_r;
    digits_nxt  = digits_r;
    discard_nxt = discard_r;
    failed      = 1'b0;
    job         = '0;

    if (accept) begin
      if (!discard_r) begin
        case (mode_r)
          MODE_TEXT: begin
            if (b == CH_AMP) begin
              mode_nxt   = MODE_NAME;
              hex_nxt    = 1'b0;
              chars_nxt  = '0;
              len_nxt    = 3'd0;
              bad_nxt    = 1'b0;
              code_nxt   = 21'd0;
              digits_nxt = 1'b0;
            end else begin
              job.bytes[0] = b;
              job.count    = 3'd1;
            end
          end
          MODE_NAME: begin
            if (b == CH_SEMI) begin
              if (name_ok) begin
                job.bytes[0] = name_out;
                job.count    = 3'd1;
              end else begin
                failed = 1'b1;
              end
              mode_nxt = MODE_TEXT;
            end else if (b == CH_HASH && len_r == 3'd0 && !bad_r) begin
              mode_nxt = MODE_HASH;
            end else if (len_r < 3'd4) begin
              chars_nxt[len_r[1:0]] = b;
              len_nxt = len_r + 3'd1;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          MODE_HASH: begin
            if (b == CH_SEMI) begin
              failed   = 1'b1;
              mode_nxt = MODE_TEXT;
            end else if (b == CH_LX || b == CH_UX) begin
              hex_nxt  = 1'b1;
              mode_nxt = MODE_DIGITS;
            end else begin
              mode_nxt = MODE_DIGITS;
              if (dig_ok) begin
                digits_nxt = 1'b1;
                code_nxt   = (dig_sum > CP_MAX) ? CP_SAT : dig_sum[20:0];
              end else begin
                bad_nxt = 1'b1;
              end
            end
          end
          MODE_DIGITS: begin
            if (b == CH_SEMI) begin
              if (code_ok) begin
                job.bytes = utf_bytes;
                job.count = utf_count;
              end else begin
                failed = 1'b1;
              end
              mode_nxt = MODE_TEXT;
            end else if (dig_ok) begin
              digits_nxt = 1'b1;
              code_nxt   = (dig_sum > CP_MAX) ? CP_SAT : dig_sum[20:0];
            end else begin
              bad_nxt = 1'b1;
            end
          end
          default: mode_nxt = MODE_TEXT;
        endcase
        // Closing an entity returns to plain text with a clean entity.
        if (mode_nxt == MODE_TEXT && mode_r != MODE_TEXT) begin
          hex_nxt    = 1'b0;
          chars_nxt  = '0;
          len_nxt    = 3'd0;
          bad_nxt    = 1'b0;
          code_nxt   = 21'd0;
          digits_nxt = 1'b0;
        end
        if (failed) begin
          discard_nxt = 1'b1;
        end
      end

      if (in_data.end_of_text) begin
        job.tail_valid = 1'b1;
        job.tail_done  = 1'b1;
        job.tail_err   = discard_nxt || (mode_nxt != MODE_TEXT);
        mode_nxt    = MODE_TEXT;
        hex_nxt     = 1'b0;
        chars_nxt   = '0;
        len_nxt     = 3'd0;
        bad_nxt     = 1'b0;
        code_nxt    = 21'd0;
        digits_nxt  = 1'b0;
        discard_nxt = 1'b0;
      end else if (failed) begin
        job.tail_valid = 1'b1;
        job.tail_err   = 1'b1;
      end
    end
  end

  assign job_push = accept && ((job.count != 3'd0) || job.tail_valid);

endmodule

`default_nettype wire

// ===== rtl/xed_queue.sv =====
// ----------------------------------------------------------------------------
// xed_queue
// Small job queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xed_queue #(
  parameter int DEPTH = xed_pkg::XED_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  xed_pkg::xed_job_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output xed_pkg::xed_job_t rd_data,
  output logic              q_empty
);
  import xed_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xed_job_t        slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

`include "xml_entity_decoder_assert.svh"

  `XED_NEVER(a_no_overflow, wr_en && full, "job written into a full queue")
  `XED_NEVER(a_no_underflow, rd_en && q_empty, "job taken from an empty queue")
  `XED_ASSERT(a_count_up, (wr_en && !rd_en) |=> (count_r == $past(count_r) + 1'b1), "queue count did not advance on write")

endmodule

`default_nettype wire

// ===== rtl/xed_back.sv =====
// ----------------------------------------------------------------------------
// xed_back
// Result sequencer: expands each job into result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xed_back (
  input  logic              clk,
  input  logic              rst_n,
  input  xed_pkg::xed_job_t head,
  input  logic              q_empty,
  output logic              q_pop,
  output xed_pkg::xed_out_t out_data,
  output logic              empty,
  input  logic              pop
);
  import xed_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  xed_out_t   out_r, out_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       last;
  logic       load;

  assign total = head.count + {2'b00, head.tail_valid};
  assign last  = (idx_r == total - 3'd1);
  assign load  = !q_empty && (!out_valid_r || pop);
  assign q_pop = load && last;

  assign out_data = out_r;
  assign empty    = !out_valid_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (idx_r < head.count) begin
        out_nxt.out_byte     = head.bytes[idx_r[1:0]];
        out_nxt.byte_valid   = 1'b1;
        out_nxt.text_done    = 1'b0;
        out_nxt.entity_error = 1'b0;
      end else begin
        out_nxt.out_byte     = 8'h00;
        out_nxt.byte_valid   = 1'b0;
        out_nxt.text_done    = head.tail_done;
        out_nxt.entity_error = head.tail_err;
      end
      out_nxt.run_last = last;
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/xml_entity_decoder.sv =====
// ----------------------------------------------------------------------------
// xml_entity_decoder
// XML character reference decoder with UTF-8 output, queue interfaces.
// ----------------------------------------------------------------------------
// Feed text bytes through push/full; take decoded results through pop/empty.
// Plain bytes pass through, named entities (lt, gt, amp, quot, apos, nbsp,
// cr) give one byte, and numeric references (&#ddd;, &#xhhh;) give one to
// four UTF-8 bytes. A bad entity yields an error result and every byte after
// it up to end_of_text is dropped; each text ends with one closing result.
// Rate: one input transaction per cycle while the job queue has room; each
// result is loaded into the output register in turn, so a byte that expands
// into k results holds the result sequencer until all k are loaded. A job
// queue of QUEUE_DEPTH entries sits between the parser and the sequencer,
// and input stalls (full high) only while it is full. When nothing is
// waiting, the first result of an accepted byte is written into the job
// queue, then loaded into the output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xml_entity_decoder #(
  parameter int QUEUE_DEPTH = xed_pkg::XED_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // input queue side
  input  logic              push,
  output logic              full,
  input  xed_pkg::xed_in_t  in_data,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output xed_pkg::xed_out_t out_data
);
  import xed_pkg::*;

  logic     accept;
  xed_job_t job;
  logic     job_push;
  xed_job_t head;
  logic     q_empty;
  logic     q_pop;

  // A transaction is taken whenever the job queue has room, even if the
  // byte turns out to produce no result.
  assign accept = push && !full;

  // Parser: tracks entity state and builds at most one job per byte.
  xed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .job      (job),
    .job_push (job_push)
  );

  // Decouple parsing from result delivery so each side can stall alone.
  xed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (head),
    .q_empty (q_empty)
  );

  // Sequencer: walk the head job one result per cycle into the output register
  // while it is empty or popped; pop the queue as its last result is loaded.
  xed_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire

// ===== bench/tb_xml_entity_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xml_entity_decoder
// Self-checking bench for the XML character reference decoder.
// ----------------------------------------------------------------------------
// Streams texts through the input queue and pops results through the output
// queue, both sides with random gaps. A behavioral decoder runs alongside,
// computes the results of every accepted byte and holds them in arrival
// order; each popped result is checked against the oldest of them. A short
// directed set of texts opens the run, then random texts mix plain bytes,
// well-formed entities with random content and broken or noisy ones.
// ----------------------------------------------------------------------------
module tb_xml_entity_decoder;
  import xed_pkg::*;

  localparam int unsigned CP_MAX = 'h10FFFF;
  localparam int unsigned CP_SAT = 'h1FFFFF;
  localparam int RANDOM_BYTES = 220;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     push = 1'b0;
  logic     full;
  xed_in_t  in_data = '0;
  logic     empty;
  logic     pop = 1'b0;
  xed_out_t out_data;

  xml_entity_decoder uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Stimulus bytes waiting for the driver, and decoded results waiting for
  // the output side, oldest first.
  xed_in_t  text_q[$];
  xed_out_t decoded_q[$];
  logic [7:0] seg[$];

  string entity_names[7] = '{"lt", "gt", "amp", "quot", "apos", "nbsp", "cr"};

  int mismatches = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int texts_built = 0;
  int in_gap = 0;
  int out_gap = 0;

  // Shadow decoder state.
  xed_mode_t   mode = MODE_TEXT;
  bit          hex_ref = 1'b0;
  logic [31:0] name_buf = '0;
  logic [2:0]  name_len = '0;
  bit          ent_bad = 1'b0;
  logic [20:0] code_pt = '0;
  bit          have_digit = 1'b0;
  bit          dropping = 1'b0;

  // One quarter of the time both sides run without any idling.
  logic [9:0] phase_cnt = '0;
  logic       steady;
  assign steady = &phase_cnt[9:8];
  always @(posedge clk) begin
    phase_cnt <= phase_cnt + 1'b1;
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder
  // --------------------------------------------------------------------------
  function automatic void clear_entity();
    mode = MODE_TEXT;
    hex_ref = 1'b0;
    name_buf = '0;
    name_len = '0;
    ent_bad = 1'b0;
    code_pt = '0;
    have_digit = 1'b0;
  endfunction

  function automatic xed_out_t byte_result(logic [7:0] b);
    xed_out_t r;
    r = '0;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  // Accumulate one digit; a byte outside the current base marks the
  // reference bad. Values past the code point range stick at saturation.
  function automatic void add_digit(logic [7:0] b);
    int unsigned v;
    int unsigned acc;
    if (b >= "0" && b <= "9") begin
      v = b - "0";
    end else if (hex_ref && b >= "a" && b <= "f") begin
      v = b - "a" + 10;
    end else if (hex_ref && b >= "A" && b <= "F") begin
      v = b - "A" + 10;
    end else begin
      ent_bad = 1'b1;
      return;
    end
    have_digit = 1'b1;
    acc = code_pt * (hex_ref ? 16 : 10) + v;
    if (acc > CP_MAX) acc = CP_SAT;
    code_pt = acc[20:0];
  endfunction

  // Name bytes are packed with the first byte in the low bits.
  function automatic bit lookup_name(output logic [7:0] nb);
    nb = 8'h00;
    if (ent_bad) return 1'b0;
    case ({name_len, name_buf})
      {3'd2, 16'h0000, "t", "l"}: nb = "<";
      {3'd2, 16'h0000, "t", "g"}: nb = ">";
      {3'd3, 8'h00, "p", "m", "a"}: nb = "&";
      {3'd4, "t", "o", "u", "q"}: nb = 8'h22;
      {3'd4, "s", "o", "p", "a"}: nb = 8'h27;
      {3'd4, "p", "s", "b", "n"}: nb = " ";
      {3'd2, 16'h0000, "r", "c"}: nb = 8'h0A;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Work out every result one accepted byte causes and queue them.
  function automatic void decode_text_byte(xed_in_t item);
    xed_out_t    step_q[$];
    xed_out_t    r;
    logic [7:0]  b;
    logic [7:0]  nb;
    int unsigned c;
    bit          failed;
    b = item.text_byte;
    failed = 1'b0;
    if (!dropping) begin
      case (mode)
        MODE_TEXT: begin
          if (b == "&") begin
            clear_entity();
            mode = MODE_NAME;
          end else begin
            step_q = {step_q, byte_result(b)};
          end
        end
        MODE_NAME: begin
          if (b == ";") begin
            if (lookup_name(nb)) step_q = {step_q, byte_result(nb)};
            else failed = 1'b1;
            clear_entity();
          end else if (b == "#" && name_len == 0 && !ent_bad) begin
            mode = MODE_HASH;
          end else if (name_len < 4) begin
            name_buf = name_buf | (32'(b) << (8 * name_len));
            name_len = name_len + 1'b1;
          end else begin
            ent_bad = 1'b1;
          end
        end
        MODE_HASH: begin
          if (b == ";") begin
            failed = 1'b1;
            clear_entity();
          end else if (b == "x" || b == "X") begin
            hex_ref = 1'b1;
            mode = MODE_DIGITS;
          end else begin
            add_digit(b);
            mode = MODE_DIGITS;
          end
        end
        default: begin
          if (b == ";") begin
            c = code_pt;
            if (ent_bad || !have_digit || c == 0 || c > CP_MAX ||
                (c >= 'hD800 && c <= 'hDFFF)) begin
              failed = 1'b1;
            end else if (c <= 'h7F) begin
              step_q = {step_q, byte_result(c[7:0])};
            end else if (c <= 'h7FF) begin
              step_q = {step_q, byte_result(8'hC0 | 8'(c >> 6))};
              step_q = {step_q, byte_result(8'h80 | 8'(c & 'h3F))};
            end else if (c <= 'hFFFF) begin
              step_q = {step_q, byte_result(8'hE0 | 8'(c >> 12))};
              step_q = {step_q, byte_result(8'h80 | 8'((c >> 6) & 'h3F))};
              step_q = {step_q, byte_result(8'h80 | 8'(c & 'h3F))};
            end else begin
              step_q = {step_q, byte_result(8'hF0 | 8'(c >> 18))};
              step_q = {step_q, byte_result(8'h80 | 8'((c >> 12) & 'h3F))};
              step_q = {step_q, byte_result(8'h80 | 8'((c >> 6) & 'h3F))};
              step_q = {step_q, byte_result(8'h80 | 8'(c & 'h3F))};
            end
            clear_entity();
          end else begin
            add_digit(b);
          end
        end
      endcase
      if (failed) begin
        dropping = 1'b1;
        clear_entity();
      end
    end

    // An entity still open at the end of the text counts as an error on
    // the closing result.
    if (item.end_of_text) begin
      if (!dropping && mode != MODE_TEXT) dropping = 1'b1;
      r = '0;
      r.text_done = 1'b1;
      r.entity_error = dropping;
      step_q = {step_q, r};
      clear_entity();
      dropping = 1'b0;
    end else if (failed) begin
      r = '0;
      r.entity_error = 1'b1;
      step_q = {step_q, r};
    end

    if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
    decoded_q = {decoded_q, step_q};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic int idle_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Add one byte to the text being assembled.
  function automatic void append_seg(logic [7:0] b);
    seg = {seg, b};
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) append_seg(s[i]);
  endfunction

  function automatic logic [7:0] letter();
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  // Append the digits of v, with optional leading zeros and hex digits in
  // mixed case.
  function automatic void put_number(int unsigned v, bit hex, int zeros);
    logic [7:0]  digits[$];
    int unsigned d;
    do begin
      d = hex ? v % 16 : v % 10;
      if (d < 10) digits.push_front(8'("0" + d));
      else digits.push_front(8'(($urandom_range(0, 1) ? "A" : "a") + d - 10));
      v = hex ? v / 16 : v / 10;
    end while (v != 0);
    repeat (zeros) append_seg("0");
    foreach (digits[i]) append_seg(digits[i]);
  endfunction

  function automatic void put_reference(int unsigned v);
    bit hex;
    hex = $urandom_range(0, 1);
    if (hex) put_str($urandom_range(0, 1) ? "&#x" : "&#X");
    else put_str("&#");
    put_number(v, hex, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    append_seg(";");
  endfunction

  function automatic int unsigned valid_code_point();
    int unsigned v;
    int unsigned edges[10] = '{1, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF,
                                'h10000, 'h10FFFF};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 9)];
    case ($urandom_range(0, 3))
      0: v = $urandom_range(1, 'h7F);
      1: v = $urandom_range('h80, 'h7FF);
      2: begin
        v = $urandom_range('h800, 'hFFFF);
        if (v >= 'hD800 && v <= 'hDFFF) v = v ^ 'h4000;
      end
      default: v = $urandom_range('h10000, 'h10FFFF);
    endcase
    return v;
  endfunction

  // Move the assembled text into the stimulus queue, flagging its last byte.
  function automatic void flush_text();
    xed_in_t item;
    foreach (seg[i]) begin
      item.text_byte = seg[i];
      item.end_of_text = (i == seg.size() - 1);
      text_q = {text_q, item};
    end
    seg.delete();
    texts_built++;
  endfunction

  function automatic void queue_random_text();
    int kind;
    int nseg;
    logic [7:0] b;
    nseg = $urandom_range(1, 6);
    for (int i = 0; i < nseg; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // plain bytes; ampersands come only from entities and noise
        repeat ($urandom_range(1, 3)) begin
          b = $urandom_range(0, 255);
          append_seg((b == "&") ? 8'h26 ^ 8'h40 : b);
        end
      end else if (kind < 45) begin
        put_str({"&", entity_names[$urandom_range(0, 6)], ";"});
      end else if (kind < 68) begin
        put_reference(valid_code_point());
      end else if (kind < 72) begin
        // unknown or accidentally known short name
        append_seg("&");
        repeat ($urandom_range(1, 4)) append_seg(letter());
        append_seg(";");
      end else if (kind < 75) begin
        // known name with extra letters: unknown or too long
        put_str({"&", entity_names[$urandom_range(0, 6)]});
        repeat ($urandom_range(1, 3)) append_seg(letter());
        append_seg(";");
      end else if (kind < 78) begin
        // hash after the first name byte is just a name byte
        append_seg("&");
        append_seg(letter());
        append_seg("#");
        if ($urandom_range(0, 1)) append_seg(letter());
        append_seg(";");
      end else if (kind < 81) begin
        case ($urandom_range(0, 3))
          0: put_str("&;");
          1: put_str("&#;");
          2: put_str("&#x;");
          default: put_str("&#X;");
        endcase
      end else if (kind < 84) begin
        // bad digit somewhere after the first digit
        put_str($urandom_range(0, 1) ? "&#x" : "&#");
        put_number($urandom_range(1, 999), 1'b0, 0);
        append_seg(8'("g" + $urandom_range(0, 19)));
        if ($urandom_range(0, 1)) put_number($urandom_range(0, 99), 1'b0, 0);
        append_seg(";");
      end else if (kind < 87) begin
        if ($urandom_range(0, 1)) begin
          put_reference($urandom_range('h110000, 'hFFFFFF));
        end else begin
          // long decimal run, mostly past the code point range, where it saturates and stays saturated
          put_str("&#");
          append_seg(8'("1" + $urandom_range(0, 8)));
          repeat ($urandom_range(6, 11)) append_seg(8'("0" + $urandom_range(0, 9)));
          append_seg(";");
        end
      end else if (kind < 90) begin
        put_reference(($urandom_range(0, 3) == 0) ? 0 : $urandom_range('hD800, 'hDFFF));
      end else if (kind < 93) begin
        // entity left open at the end of the text
        case ($urandom_range(0, 4))
          0: put_str("&");
          1: put_str("&lt");
          2: put_str("&#");
          3: put_str("&#x1F");
          default: put_str("&#65");
        endcase
        break;
      end else begin
        repeat ($urandom_range(1, 4)) append_seg(8'($urandom_range(0, 255)));
      end
    end
    flush_text();
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: present the next byte, hold it while full, then idle a
  // random number of cycles before the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_gap = 0;
    end else begin
      if (push && !full) begin
        decode_text_byte(in_data);
        bytes_sent++;
      end
      if (!push || !full) begin
        if (in_gap > 0) begin
          in_gap--;
          push <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_data <= text_q.pop_front();
          push <= 1'b1;
          in_gap = idle_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: pop with random stalls, check each transaction against
  // the oldest decoded result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    xed_out_t want;
    if (!rst_n) begin
      pop <= 1'b0;
      out_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result byte=%h valid=%b last=%b done=%b err=%b",
                     $realtime, out_data.out_byte, out_data.byte_valid,
                     out_data.run_last, out_data.text_done, out_data.entity_error);
        end else begin
          want = decoded_q.pop_front();
          results_checked++;
          if (out_data.out_byte !== want.out_byte ||
              out_data.byte_valid !== want.byte_valid ||
              out_data.run_last !== want.run_last ||
              out_data.text_done !== want.text_done ||
              out_data.entity_error !== want.entity_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result %0d mismatch: expected byte=%h valid=%b last=%b ",
                        "done=%b err=%b, got byte=%h valid=%b last=%b done=%b err=%b"},
                       $realtime, results_checked, want.out_byte, want.byte_valid,
                       want.run_last, want.text_done, want.entity_error,
                       out_data.out_byte, out_data.byte_valid, out_data.run_last,
                       out_data.text_done, out_data.entity_error);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        out_gap = idle_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build stimulus, reset, drain, report.
  // --------------------------------------------------------------------------
  initial begin
    // Directed texts: plain extremes, then one text per error flavor.
    append_seg(8'h00);
    append_seg(8'hFF);
    flush_text();
    put_str("&;z");       // empty entity, then a dropped byte
    flush_text();
    put_str("&quots;");   // name too long
    flush_text();
    put_str("&a#;");      // hash inside a name
    flush_text();
    put_str("&#7g;");     // bad decimal digit
    flush_text();
    put_str("&#0;");      // code point zero
    flush_text();
    put_str("&#9");       // no closing semicolon
    flush_text();

    while (text_q.size() < RANDOM_BYTES) queue_random_text();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every byte accepted, every result popped, then a quiet spell
    // to catch anything extra.
    while (text_q.size() != 0 || push) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d texts, %0d bytes accepted, %0d results checked, %0d mismatches.",
             texts_built, bytes_sent, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("xml_entity_decoder regression: pass");
    end else begin
      $display("xml_entity_decoder regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Timed out with %0d results still awaited.", decoded_q.size());
    $display("xml_entity_decoder regression: fail");
    $finish;
  end

endmodule
